// ===== rtl/lkvc_pkg.sv =====
// Shared types and constants for the LRU key/value cache.
package lkvc_pkg;

  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0]         CAP_RESET  = 5'd16;
  localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;
  localparam logic signed [DATA_W-1:0] PUT_VALUE  = 32'sd0;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic                     op;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;
    logic                     evicted;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
  } status_t;

endpackage

// ===== rtl/lru_key_value_cache_top.sv =====
// Top level of the LRU key/value cache: capacity register, controller and datapath.
// A new request is taken only while idle; busy is high while a request is in flight,
//   set by the serial scan of the slot memories, one slot per cycle.
// Results show for one cycle on result with result_valid; the receiver cannot stall.
// Reset (rst, synchronous): empties the cache, capacity returns to 16; no clearing pass.
module lru_key_value_cache_top import lkvc_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  req_t             req,
  output result_t          result,
  output logic             result_valid,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  logic [CAP_W-1:0] capacity;
  cmd_t             cmd;
  status_t          status;

  // Take a configuration beat at any time; by contract writes land only while idle, and the block does not enforce it.
  assign cfg_ready = 1'b1;

  // Hold the capacity; zero and oversize values are clamped in the datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  // Sequence each request: load, scan every slot, then finish and write back.
  lkvc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Scan the slots for the key, a free slot and the oldest entry; the recency
  // update of each request is folded into the scan of the next one.
  lkvc_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .req          (req),
    .capacity     (capacity),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

// ===== rtl/lkvc_ctrl.sv =====
// Controller state machine: sequences load, slot scan and finish of one request.
module lkvc_ctrl import lkvc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.scan_done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_SCAN: begin
        cmd = '0;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/lkvc_datapath.sv =====
// Datapath: slot memories, serial slot scan, lazy age-rank update and result register.
module lkvc_datapath import lkvc_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  output status_t          status,
  input  req_t             req,
  input  logic [CAP_W-1:0] capacity,
  output result_t          result,
  output logic             result_valid
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [CMP_W-1:0] MAX_CAP  = CMP_W'(ENTRIES);

  logic signed [DATA_W-1:0] key_mem   [ENTRIES];
  logic signed [DATA_W-1:0] value_mem [ENTRIES];
  logic [IDX_W-1:0]         rank_mem  [ENTRIES];

  logic [ENTRIES-1:0] valid;
  logic [CNT_W-1:0]   used_count;
  req_t               req_q;

  // scan pipeline: issue stage and check stage
  logic                     rd_go;
  logic [IDX_W-1:0]         rd_idx;
  logic                     chk_go;
  logic [IDX_W-1:0]         chk_idx;
  logic signed [DATA_W-1:0] key_rd;
  logic signed [DATA_W-1:0] value_rd;
  logic [IDX_W-1:0]         rank_rd;

  // scan findings
  logic                     found;
  logic [IDX_W-1:0]         found_idx;
  logic [IDX_W-1:0]         found_rank;
  logic signed [DATA_W-1:0] found_value;
  logic                     free_found;
  logic [IDX_W-1:0]         free_idx;
  logic [IDX_W-1:0]         victim_idx;
  logic [IDX_W-1:0]         victim_rank;

  // recency update left over from the previous request
  logic             pend;
  logic             pend_all;
  logic [IDX_W-1:0] pend_slot;
  logic [IDX_W-1:0] pend_limit;

  logic             chk_slot_valid;
  logic [IDX_W-1:0] rank_fix;
  logic [CNT_W-1:0] used_minus_one;
  logic             is_victim;

  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] eff_cap;
  logic             has_room;

  logic             mem_we;
  logic [IDX_W-1:0] wr_idx;
  logic             set_valid;
  result_t          result_next;
  logic             pend_next;
  logic             pend_all_next;
  logic [IDX_W-1:0] pend_slot_next;
  logic [IDX_W-1:0] pend_limit_next;

  assign status.scan_done = chk_go && !rd_go;

  always_comb begin
    chk_slot_valid = valid[chk_idx];
    used_minus_one = used_count - CNT_W'(1);
    if (pend && (chk_idx == pend_slot)) begin
      rank_fix = '0;
    end else if (pend && chk_slot_valid && (pend_all || (rank_rd < pend_limit))) begin
      rank_fix = rank_rd + IDX_W'(1);
    end else begin
      rank_fix = rank_rd;
    end
    is_victim = chk_slot_valid && (CNT_W'(rank_fix) == used_minus_one);
  end

  // issue stage
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_go  <= 1'b0;
      chk_go <= 1'b0;
    end else begin
      if (cmd.load) begin
        rd_go <= 1'b1;
      end else if (rd_go && (rd_idx == LAST_IDX)) begin
        rd_go <= 1'b0;
      end
      chk_go <= rd_go;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_idx <= '0;
    end else if (rd_go) begin
      rd_idx <= rd_idx + IDX_W'(1);
    end
    if (rd_go) begin
      chk_idx <= rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_go) begin
      key_rd   <= key_mem[rd_idx];
      value_rd <= value_mem[rd_idx];
      rank_rd  <= rank_mem[rd_idx];
    end
  end

  // write back the corrected rank of each slot as it passes
  always_ff @(posedge clk) begin
    if (chk_go) begin
      rank_mem[chk_idx] <= rank_fix;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[wr_idx]   <= req_q.key;
      value_mem[wr_idx] <= req_q.value;
    end
  end

  // check stage
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q      <= req;
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if (chk_go) begin
      if (chk_slot_valid && (key_rd == req_q.key) && !found) begin
        found       <= 1'b1;
        found_idx   <= chk_idx;
        found_rank  <= rank_fix;
        found_value <= value_rd;
      end
      if (!chk_slot_valid && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= chk_idx;
      end
      if (is_victim) begin
        victim_idx  <= chk_idx;
        victim_rank <= rank_fix;
      end
    end
  end

  always_comb begin
    cap_ext = CMP_W'(capacity);
    if (capacity == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > MAX_CAP) begin
      eff_cap = MAX_CAP;
    end else begin
      eff_cap = cap_ext;
    end
    has_room = CMP_W'(used_count) < eff_cap;
  end

  always_comb begin
    mem_we          = 1'b0;
    wr_idx          = found_idx;
    set_valid       = 1'b0;
    result_next     = '0;
    pend_next       = 1'b0;
    pend_all_next   = 1'b0;
    pend_slot_next  = found_idx;
    pend_limit_next = found_rank;
    if (req_q.op == OP_GET) begin
      result_next.hit        = found;
      result_next.read_value = found ? found_value : MISS_VALUE;
      pend_next              = found;
    end else if (found) begin
      result_next.hit        = 1'b1;
      result_next.read_value = PUT_VALUE;
      mem_we                 = 1'b1;
      pend_next              = 1'b1;
    end else if (has_room) begin
      result_next.read_value = PUT_VALUE;
      mem_we                 = 1'b1;
      wr_idx                 = free_idx;
      set_valid              = 1'b1;
      pend_next              = 1'b1;
      pend_all_next          = 1'b1;
      pend_slot_next         = free_idx;
    end else begin
      result_next.read_value = PUT_VALUE;
      result_next.evicted    = 1'b1;
      mem_we                 = 1'b1;
      wr_idx                 = victim_idx;
      pend_next              = 1'b1;
      pend_slot_next         = victim_idx;
      pend_limit_next        = victim_rank;
    end
    mem_we    = mem_we && cmd.finish;
    set_valid = set_valid && cmd.finish;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid        <= '0;
      used_count   <= '0;
      pend         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.finish;
      if (cmd.finish) begin
        pend <= pend_next;
      end
      if (set_valid) begin
        valid[wr_idx] <= 1'b1;
        used_count    <= used_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result     <= result_next;
      pend_all   <= pend_all_next;
      pend_slot  <= pend_slot_next;
      pend_limit <= pend_limit_next;
    end
  end

endmodule
